FILE: src/utf8_codepoint_decoder_unit_macros.svh
// assertion macros shared by the decoder checker
`ifndef UTF8_CODEPOINT_DECODER_UNIT_MACROS_SVH
`define UTF8_CODEPOINT_DECODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define UCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define UCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg
// types and constants shared by the utf-8 code point decoder
// ----------------------------------------------------------------------------
package ucd_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int PAY_W  = 7;

	// byte class decided by the front end
	typedef enum logic [2:0] {
		KIND_ASCII,
		KIND_LEAD2,
		KIND_LEAD3,
		KIND_LEAD4,
		KIND_CONT,
		KIND_DROP
	} ucd_kind_t;

	// one classified byte as it sits in the queue
	typedef struct packed {
		ucd_kind_t          kind;
		logic [PAY_W-1:0]   bits;
		logic               last;
	} ucd_entry_t;

endpackage

FILE: src/ucd_byte_if.sv
// ----------------------------------------------------------------------------
// ucd_byte_if
// byte channel into the decoder: valid, ready and one text byte
// ----------------------------------------------------------------------------
interface ucd_byte_if;

	logic                        valid;
	logic                        ready;
	logic [ucd_pkg::BYTE_W-1:0]  text_byte;
	logic                        end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);

endinterface

FILE: src/ucd_cp_if.sv
// ----------------------------------------------------------------------------
// ucd_cp_if
// code point channel out of the decoder: valid, ready and one result
// ----------------------------------------------------------------------------
interface ucd_cp_if;

	logic                      valid;
	logic                      ready;
	logic [ucd_pkg::CP_W-1:0]  code_point;
	logic                      has_char;
	logic                      last_of_text;

	modport source (output valid, output code_point, output has_char,
		output last_of_text, input ready);
	modport sink   (input valid, input code_point, input has_char,
		input last_of_text, output ready);

endinterface

FILE: src/utf8_codepoint_decoder_unit.sv
// path: the completing byte is written into a queue slot, then its result into the output register
// throughput: one byte per cycle while the output is taken, set by the state update in the back end
// a full output register that is not taken stalls the back end, then the queue fills
// reset: asynchronous, clears sequence state, queue pointers and output valid
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_unit
// streaming utf-8 decoder: classifying front end, queue, assembling back end
// ----------------------------------------------------------------------------
module utf8_codepoint_decoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	ucd_byte_if.sink   byte_chan,
	ucd_cp_if.source   cp_chan
);

	logic                 push_valid;
	logic                 push_ready;
	ucd_pkg::ucd_entry_t  push_entry;
	logic                 pop_valid;
	logic                 pop_ready;
	ucd_pkg::ucd_entry_t  pop_entry;

	// classify incoming bytes
	ucd_front u_front (
		.byte_chan  (byte_chan),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_entry (push_entry)
	);

	// decouple front and back end
	ucd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// assemble code points
	ucd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.cp_chan   (cp_chan)
	);

endmodule

FILE: src/ucd_front.sv
// ----------------------------------------------------------------------------
// ucd_front
// accepts text bytes and classifies each into a queue entry
// ----------------------------------------------------------------------------
module ucd_front (
	ucd_byte_if.sink              byte_chan,
	input  logic                  push_ready,
	output logic                  push_valid,
	output ucd_pkg::ucd_entry_t   push_entry
);

	logic [ucd_pkg::BYTE_W-1:0] b;

	assign b = byte_chan.text_byte;

	// a byte moves on whenever the queue has room
	assign byte_chan.ready = push_ready;
	assign push_valid      = byte_chan.valid;

	// classify by the high bits, keep only the payload bits of the byte
	always_comb begin
		push_entry.last = byte_chan.end_of_text;
		push_entry.bits = '0;
		if (b[7] == 1'b0) begin
			push_entry.kind = ucd_pkg::KIND_ASCII;
			push_entry.bits = b[6:0];
		end else if (b[7:6] == 2'b10) begin
			push_entry.kind = ucd_pkg::KIND_CONT;
			push_entry.bits = {1'b0, b[5:0]};
		end else if (b[7:5] == 3'b110) begin
			push_entry.kind = ucd_pkg::KIND_LEAD2;
			push_entry.bits = {2'b00, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			push_entry.kind = ucd_pkg::KIND_LEAD3;
			push_entry.bits = {3'b000, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			push_entry.kind = ucd_pkg::KIND_LEAD4;
			push_entry.bits = {4'b0000, b[2:0]};
		end else begin
			push_entry.kind = ucd_pkg::KIND_DROP;
		end
	end

endmodule

FILE: src/ucd_queue.sv
// ----------------------------------------------------------------------------
// ucd_queue
// small fifo of classified bytes between front and back end
// ----------------------------------------------------------------------------
module ucd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  ucd_pkg::ucd_entry_t   push_entry,
	output logic                  pop_valid,
	input  logic                  pop_ready,
	output ucd_pkg::ucd_entry_t   pop_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ucd_pkg::ucd_entry_t slot_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_entry  = slot_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/ucd_back.sv
// ----------------------------------------------------------------------------
// ucd_back
// sequence state, code point assembly and the output register
// ----------------------------------------------------------------------------
module ucd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pop_valid,
	output logic                  pop_ready,
	input  ucd_pkg::ucd_entry_t   pop_entry,
	ucd_cp_if.source              cp_chan
);

	logic [1:0]                due_q;
	logic [ucd_pkg::CP_W-1:0]  partial_q;
	logic                      out_valid_q;
	logic [ucd_pkg::CP_W-1:0]  code_q;
	logic                      has_q;
	logic                      last_q;

	logic [1:0]                due_d;
	logic [ucd_pkg::CP_W-1:0]  partial_d;
	logic [ucd_pkg::CP_W-1:0]  cp;
	logic                      done;
	logic                      emit;
	logic                      pop;

	// take an entry whenever the output register is free or draining
	assign pop_ready = !out_valid_q || cp_chan.ready;
	assign pop       = pop_valid && pop_ready;

	// next sequence state and the character completed by this entry
	always_comb begin
		due_d     = due_q;
		partial_d = partial_q;
		cp        = '0;
		done      = 1'b0;
		if (due_q != 2'd0 && pop_entry.kind == ucd_pkg::KIND_CONT) begin
			partial_d = {partial_q[ucd_pkg::CP_W-7:0], pop_entry.bits[5:0]};
			due_d     = due_q - 2'd1;
			if (due_d == 2'd0) begin
				cp        = partial_d;
				partial_d = '0;
				done      = 1'b1;
			end
		end else begin
			// no open sequence, or it broke: look at the byte afresh
			due_d     = 2'd0;
			partial_d = '0;
			case (pop_entry.kind)
				ucd_pkg::KIND_ASCII: begin
					cp   = ucd_pkg::CP_W'(pop_entry.bits);
					done = 1'b1;
				end
				ucd_pkg::KIND_LEAD2: begin
					due_d     = 2'd1;
					partial_d = ucd_pkg::CP_W'(pop_entry.bits);
				end
				ucd_pkg::KIND_LEAD3: begin
					due_d     = 2'd2;
					partial_d = ucd_pkg::CP_W'(pop_entry.bits);
				end
				ucd_pkg::KIND_LEAD4: begin
					due_d     = 2'd3;
					partial_d = ucd_pkg::CP_W'(pop_entry.bits);
				end
				default: begin
					due_d     = 2'd0;
					partial_d = '0;
				end
			endcase
		end
		// end of text always yields a result and starts clean
		if (pop_entry.last) begin
			due_d     = 2'd0;
			partial_d = '0;
		end
		emit = done || pop_entry.last;
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_q     <= 2'd0;
			partial_q <= '0;
		end else if (pop) begin
			due_q     <= due_d;
			partial_q <= partial_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= emit || (out_valid_q && !cp_chan.ready);
		end else if (cp_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			code_q <= cp;
			has_q  <= done;
			last_q <= pop_entry.last;
		end
	end

	assign cp_chan.valid        = out_valid_q;
	assign cp_chan.code_point   = code_q;
	assign cp_chan.has_char     = has_q;
	assign cp_chan.last_of_text = last_q;

endmodule

FILE: src/ucd_checker.sv
// ----------------------------------------------------------------------------
// ucd_checker
// port-level checks on the decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "utf8_codepoint_decoder_unit_macros.svh"

module ucd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_end,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [ucd_pkg::CP_W-1:0]  out_code,
	input logic                      out_has,
	input logic                      out_last
);

	logic seen_in_q;
	logic seen_end_q;

	// remember whether any byte, and any final byte, has gone in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q  <= 1'b0;
			seen_end_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			seen_in_q <= 1'b1;
			if (in_end) begin
				seen_end_q <= 1'b1;
			end
		end
	end

	// a stalled result keeps its payload
	`UCD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_code) && $stable(out_has) && $stable(out_last), "stalled result changed")

	// an empty result only marks the end of text, and carries zero
	`UCD_ASSERT_NOW(a_empty, out_valid && !out_has, out_last && out_code == '0, "empty result not at end of text")

	// no result before any byte was taken
	`UCD_ASSERT_NOW(a_cause, out_valid, seen_in_q, "result without input")

	// an end-of-text result needs a final byte taken earlier
	`UCD_ASSERT_NOW(a_end, out_valid && out_last, seen_end_q, "end of text without final byte")

endmodule

bind utf8_codepoint_decoder_unit ucd_checker u_ucd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (byte_chan.valid),
	.in_ready  (byte_chan.ready),
	.in_end    (byte_chan.end_of_text),
	.out_valid (cp_chan.valid),
	.out_ready (cp_chan.ready),
	.out_code  (cp_chan.code_point),
	.out_has   (cp_chan.has_char),
	.out_last  (cp_chan.last_of_text)
);
